// ===== sv/vmx_pkg.sv =====
// Shared types, opcodes, status codes and helper functions for the VM instruction executor.
// Has no dependencies; every other file refers to it by scoped names.
package vmx_pkg;

  localparam int NUM_REGS_DEF   = 256;
  localparam int HEAP_BYTES_DEF = 8192;

  localparam int PC_W   = 16;
  localparam int WORD_W = 32;
  localparam int CODE_W = 18;
  localparam int BYTE_W = 8;

  localparam logic [7:0] OP_HALT  = 8'h00;
  localparam logic [7:0] OP_LOAD  = 8'h10;
  localparam logic [7:0] OP_STORE = 8'h20;
  localparam logic [7:0] OP_MOVE  = 8'h30;
  localparam logic [7:0] OP_IMM   = 8'h40;
  localparam logic [7:0] OP_ADD   = 8'h50;
  localparam logic [7:0] OP_SUB   = 8'h60;
  localparam logic [7:0] OP_GT    = 8'h70;
  localparam logic [7:0] OP_GE    = 8'h80;
  localparam logic [7:0] OP_EQ    = 8'h90;
  localparam logic [7:0] OP_BR    = 8'ha0;
  localparam logic [7:0] OP_JMP   = 8'hb0;
  localparam logic [7:0] OP_PRINT = 8'hc0;
  localparam logic [7:0] OP_READ  = 8'hd0;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_HALT    = 3'd1,
    ST_ILLEGAL = 3'd2,
    ST_HEAP    = 3'd3,
    ST_CODE    = 3'd4,
    ST_PRINT   = 3'd5,
    ST_READ    = 3'd6
  } status_t;

  // Outcome of executing one instruction.
  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    status_t           status;
    logic [WORD_W-1:0] wval;
    logic [WORD_W-1:0] saddr;
    logic              reg_we;
    logic              heap_we;
    logic              heap_re;
    logic              stop;
    logic [WORD_W-1:0] heap_addr;
    logic [BYTE_W-1:0] store_byte;
  } exec_res_t;

  // Field value modulo the register count, by eight conditional subtract steps.
  function automatic logic [7:0] reg_index(input logic [7:0] f, input int unsigned n);
    logic [15:0] rem;
    logic [15:0] n16;
    rem = {8'b0, f};
    n16 = 16'(n);
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (n16 << k)) begin
        rem = rem - (n16 << k);
      end
    end
    return rem[7:0];
  endfunction

  // Read port 0 holds the register named by field a for these opcodes, else field b.
  function automatic logic port0_uses_a(input logic [7:0] op);
    return (op == OP_STORE) || (op == OP_BR) || (op == OP_PRINT) || (op == OP_READ);
  endfunction

  // Read port 1 holds the register named by field b for a store, else field c.
  function automatic logic port1_uses_b(input logic [7:0] op);
    return op == OP_STORE;
  endfunction

endpackage

// ===== sv/vmx_regfile.sv =====
// Register file: NUM_REGS words, two registered read ports and one write port.
// Depends on vmx_pkg for the word width.
module vmx_regfile #(
  parameter int NUM_REGS = vmx_pkg::NUM_REGS_DEF,
  localparam int RIDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  logic                      clk,
  input  logic                      re,
  input  logic [RIDX_W-1:0]         raddr0,
  input  logic [RIDX_W-1:0]         raddr1,
  output logic [vmx_pkg::WORD_W-1:0] rdata0,
  output logic [vmx_pkg::WORD_W-1:0] rdata1,
  input  logic                      we,
  input  logic [RIDX_W-1:0]         waddr,
  input  logic [vmx_pkg::WORD_W-1:0] wdata
);

  logic [vmx_pkg::WORD_W-1:0] mem [NUM_REGS];

  // Read data holds its value until the next read, so a stalled instruction keeps its operands.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== sv/vmx_heap.sv =====
// Byte heap: HEAP_BYTES bytes, one registered read port and one write port.
// Depends on vmx_pkg for the byte width.
module vmx_heap #(
  parameter int HEAP_BYTES = vmx_pkg::HEAP_BYTES_DEF,
  localparam int HADDR_W   = $clog2(HEAP_BYTES)
) (
  input  logic                       clk,
  input  logic                       re,
  input  logic [HADDR_W-1:0]         raddr,
  output logic [vmx_pkg::BYTE_W-1:0] rdata,
  input  logic                       we,
  input  logic [HADDR_W-1:0]         waddr,
  input  logic [vmx_pkg::BYTE_W-1:0] wdata
);

  logic [vmx_pkg::BYTE_W-1:0] mem [HEAP_BYTES];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== sv/vmx_exec.sv =====
// Combinational execute logic: decodes one instruction and computes its outcome from the
// register operands, program counter, stopped flag and code size. Depends on vmx_pkg.
module vmx_exec #(
  parameter int HEAP_BYTES = vmx_pkg::HEAP_BYTES_DEF
) (
  input  logic [7:0]                  opcode,
  input  logic [7:0]                  field_a,
  input  logic [7:0]                  field_b,
  input  logic [7:0]                  field_c,
  input  logic [vmx_pkg::WORD_W-1:0]  op0,
  input  logic [vmx_pkg::WORD_W-1:0]  op1,
  input  logic [vmx_pkg::PC_W-1:0]    pc,
  input  logic                        stopped,
  input  logic [vmx_pkg::CODE_W-1:0]  code_size,
  output vmx_pkg::exec_res_t          res
);

  localparam logic [vmx_pkg::WORD_W-1:0] HEAP_LIMIT = vmx_pkg::WORD_W'(HEAP_BYTES);

  logic [vmx_pkg::WORD_W-1:0] va;
  logic [vmx_pkg::WORD_W-1:0] vb;
  logic [vmx_pkg::WORD_W-1:0] vc;
  logic                       ok_a;
  logic                       ok_b;
  logic                       ok_c;
  logic                       fault;

  // Undo the read port assignment chosen at issue.
  assign va = op0;
  assign vb = vmx_pkg::port1_uses_b(opcode) ? op1 : op0;
  assign vc = op1;

  // A target is legal when its byte offset lies inside the loaded program.
  assign ok_a = {8'b0, field_a, 2'b00} < code_size;
  assign ok_b = {8'b0, field_b, 2'b00} < code_size;
  assign ok_c = {8'b0, field_c, 2'b00} < code_size;

  always_comb begin
    res            = '0;
    res.next_pc    = pc + vmx_pkg::PC_W'(1);
    res.status     = vmx_pkg::ST_RUN;
    res.store_byte = vb[vmx_pkg::BYTE_W-1:0];
    if (stopped) begin
      res.next_pc = pc;
      res.status  = vmx_pkg::ST_HALT;
      res.stop    = 1'b1;
    end else begin
      unique case (opcode)
        vmx_pkg::OP_HALT: begin
          res.status = vmx_pkg::ST_HALT;
          res.stop   = 1'b1;
        end
        vmx_pkg::OP_LOAD: begin
          res.heap_addr = vb;
          if (vb >= HEAP_LIMIT) begin
            res.status = vmx_pkg::ST_HEAP;
          end else begin
            res.heap_re = 1'b1;
            res.reg_we  = 1'b1;
          end
        end
        vmx_pkg::OP_STORE: begin
          res.heap_addr = va;
          if (va >= HEAP_LIMIT) begin
            res.status = vmx_pkg::ST_HEAP;
          end else begin
            res.heap_we = 1'b1;
          end
        end
        vmx_pkg::OP_MOVE: begin
          res.wval   = vb;
          res.reg_we = 1'b1;
        end
        vmx_pkg::OP_IMM: begin
          res.wval   = {24'b0, field_b};
          res.reg_we = 1'b1;
        end
        vmx_pkg::OP_ADD: begin
          res.wval   = vb + vc;
          res.reg_we = 1'b1;
        end
        vmx_pkg::OP_SUB: begin
          res.wval   = vb - vc;
          res.reg_we = 1'b1;
        end
        vmx_pkg::OP_GT: begin
          res.wval   = {31'b0, vb > vc};
          res.reg_we = 1'b1;
        end
        vmx_pkg::OP_GE: begin
          res.wval   = {31'b0, vb >= vc};
          res.reg_we = 1'b1;
        end
        vmx_pkg::OP_EQ: begin
          res.wval   = {31'b0, vb == vc};
          res.reg_we = 1'b1;
        end
        vmx_pkg::OP_BR: begin
          if (!ok_b || !ok_c) begin
            res.status = vmx_pkg::ST_CODE;
          end else begin
            res.next_pc = (va != '0) ? {8'b0, field_b} : {8'b0, field_c};
          end
        end
        vmx_pkg::OP_JMP: begin
          if (!ok_a) begin
            res.status = vmx_pkg::ST_CODE;
          end else begin
            res.next_pc = {8'b0, field_a};
          end
        end
        vmx_pkg::OP_PRINT, vmx_pkg::OP_READ: begin
          if (va >= HEAP_LIMIT) begin
            res.status = vmx_pkg::ST_HEAP;
          end else begin
            res.saddr  = va;
            res.status = (opcode == vmx_pkg::OP_PRINT) ? vmx_pkg::ST_PRINT : vmx_pkg::ST_READ;
          end
        end
        default: begin
          res.status = vmx_pkg::ST_ILLEGAL;
        end
      endcase
    end

    // A fault leaves every piece of state alone except the stopped flag.
    fault = (res.status == vmx_pkg::ST_ILLEGAL) || (res.status == vmx_pkg::ST_HEAP) ||
            (res.status == vmx_pkg::ST_CODE);
    if (fault) begin
      res.next_pc = pc;
      res.wval    = '0;
      res.saddr   = '0;
      res.reg_we  = 1'b0;
      res.heap_we = 1'b0;
      res.heap_re = 1'b0;
      res.stop    = 1'b1;
    end
  end

endmodule

// ===== sv/bytecode_vm_instruction_executor_top.sv =====
// Executes one 32-bit instruction per request of a small register VM with a register file,
// a byte heap, a program counter and a sticky stopped flag. After reset the block clears
// the heap and the register file, accepting no request meanwhile (code size writes are
// taken as usual). Then it takes one instruction per cycle while the result slot is free
// and no load is pending: the register file is read at the accept edge and the instruction
// executes in the next cycle. A load in range also passes the load completion stage, as
// the heap read needs the address register first; the next instruction waits for it. The
// result register lets a new request enter while a finished result waits to be taken.
// Depends on vmx_pkg, vmx_regfile, vmx_heap and vmx_exec.
module bytecode_vm_instruction_executor_top #(
  parameter int NUM_REGS   = vmx_pkg::NUM_REGS_DEF,
  parameter int HEAP_BYTES = vmx_pkg::HEAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [vmx_pkg::CODE_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_opcode,
  input  logic [7:0]                   in_field_a,
  input  logic [7:0]                   in_field_b,
  input  logic [7:0]                   in_field_c,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vmx_pkg::PC_W-1:0]     out_next_pc,
  output logic [2:0]                   out_status,
  output logic [vmx_pkg::WORD_W-1:0]   out_written_value,
  output logic [vmx_pkg::WORD_W-1:0]   out_service_address
);

  localparam int RIDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int HADDR_W = $clog2(HEAP_BYTES);

  // Configuration and architectural state.
  logic [vmx_pkg::CODE_W-1:0] code_size_r;
  logic [vmx_pkg::PC_W-1:0]   pc_r;
  logic                       stopped_r;

  // Clearing pass after reset.
  logic               clr_busy_r;
  logic [HADDR_W-1:0] clr_idx_r;
  logic               clr_last;
  logic               clr_reg;

  // Execute stage.
  logic              ex_valid_r;
  logic [7:0]        ex_opcode_r;
  logic [7:0]        ex_field_a_r;
  logic [7:0]        ex_field_b_r;
  logic [7:0]        ex_field_c_r;
  logic [RIDX_W-1:0] ex_ra_r;
  logic [RIDX_W-1:0] ex_p0_r;
  logic [RIDX_W-1:0] ex_p1_r;

  // Load completion stage.
  logic              ld_busy_r;
  logic [RIDX_W-1:0] ld_dst_r;

  // Most recent register write, for operands read before it landed.
  logic                       fwd_v_r;
  logic [RIDX_W-1:0]          fwd_idx_r;
  logic [vmx_pkg::WORD_W-1:0] fwd_data_r;

  // Result register.
  logic                       out_valid_r;
  logic [vmx_pkg::PC_W-1:0]   out_next_pc_r;
  logic [2:0]                 out_status_r;
  logic [vmx_pkg::WORD_W-1:0] out_wval_r;
  logic [vmx_pkg::WORD_W-1:0] out_saddr_r;

  logic                       in_fire;
  logic                       out_free;
  logic                       ex_done;
  logic                       ld_done;
  logic [RIDX_W-1:0]          in_ra;
  logic [RIDX_W-1:0]          in_rb;
  logic [RIDX_W-1:0]          in_rc;
  logic [RIDX_W-1:0]          in_p0;
  logic [RIDX_W-1:0]          in_p1;
  logic [vmx_pkg::WORD_W-1:0] rd0;
  logic [vmx_pkg::WORD_W-1:0] rd1;
  logic [vmx_pkg::WORD_W-1:0] op0;
  logic [vmx_pkg::WORD_W-1:0] op1;
  logic [vmx_pkg::BYTE_W-1:0] heap_rdata;
  vmx_pkg::exec_res_t         res;

  logic                       rf_we;
  logic [RIDX_W-1:0]          rf_waddr;
  logic [vmx_pkg::WORD_W-1:0] rf_wdata;
  logic                       hp_we;
  logic [HADDR_W-1:0]         hp_waddr;
  logic [vmx_pkg::BYTE_W-1:0] hp_wdata;
  logic                       hp_re;

  assign in_ra = RIDX_W'(vmx_pkg::reg_index(in_field_a, NUM_REGS));
  assign in_rb = RIDX_W'(vmx_pkg::reg_index(in_field_b, NUM_REGS));
  assign in_rc = RIDX_W'(vmx_pkg::reg_index(in_field_c, NUM_REGS));
  assign in_p0 = vmx_pkg::port0_uses_a(in_opcode) ? in_ra : in_rb;
  assign in_p1 = vmx_pkg::port1_uses_b(in_opcode) ? in_rb : in_rc;

  assign out_free = !out_valid_r || out_ready;
  // A load hands over to the load stage and needs no result slot yet.
  assign ex_done  = ex_valid_r && !ld_busy_r && (res.heap_re || out_free);
  assign ld_done  = ld_busy_r && out_free;
  assign in_ready = !clr_busy_r && (!ex_valid_r || ex_done);
  assign in_fire  = in_valid && in_ready;

  assign clr_last = clr_idx_r == HADDR_W'(HEAP_BYTES - 1);
  assign clr_reg  = {1'b0, clr_idx_r} < (HADDR_W + 1)'(NUM_REGS);

  assign op0 = (fwd_v_r && fwd_idx_r == ex_p0_r) ? fwd_data_r : rd0;
  assign op1 = (fwd_v_r && fwd_idx_r == ex_p1_r) ? fwd_data_r : rd1;

  vmx_regfile #(
    .NUM_REGS(NUM_REGS)
  ) u_regfile (
    .clk   (clk),
    .re    (in_fire),
    .raddr0(in_p0),
    .raddr1(in_p1),
    .rdata0(rd0),
    .rdata1(rd1),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata)
  );

  vmx_heap #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_heap (
    .clk  (clk),
    .re   (hp_re),
    .raddr(res.heap_addr[HADDR_W-1:0]),
    .rdata(heap_rdata),
    .we   (hp_we),
    .waddr(hp_waddr),
    .wdata(hp_wdata)
  );

  vmx_exec #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_exec (
    .opcode   (ex_opcode_r),
    .field_a  (ex_field_a_r),
    .field_b  (ex_field_b_r),
    .field_c  (ex_field_c_r),
    .op0      (op0),
    .op1      (op1),
    .pc       (pc_r),
    .stopped  (stopped_r),
    .code_size(code_size_r),
    .res      (res)
  );

  // Register and heap write ports: the clearing pass, then load data, then execute results.
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = ex_ra_r;
    rf_wdata = res.wval;
    hp_we    = 1'b0;
    hp_waddr = res.heap_addr[HADDR_W-1:0];
    hp_wdata = res.store_byte;
    hp_re    = ex_done && res.heap_re;
    priority if (clr_busy_r) begin
      rf_we    = clr_reg;
      rf_waddr = clr_idx_r[RIDX_W-1:0];
      rf_wdata = '0;
      hp_we    = 1'b1;
      hp_waddr = clr_idx_r;
      hp_wdata = '0;
    end else if (ld_done) begin
      rf_we    = 1'b1;
      rf_waddr = ld_dst_r;
      rf_wdata = {24'b0, heap_rdata};
    end else begin
      rf_we = ex_done && res.reg_we && !res.heap_re;
      hp_we = ex_done && res.heap_we;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_size_r <= '0;
      pc_r        <= '0;
      stopped_r   <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      ex_valid_r  <= 1'b0;
      ld_busy_r   <= 1'b0;
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        code_size_r <= cfg_wdata;
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + HADDR_W'(1);
        if (clr_last) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_fire) begin
        ex_valid_r <= 1'b1;
      end else if (ex_done) begin
        ex_valid_r <= 1'b0;
      end
      if (ex_done) begin
        pc_r      <= res.next_pc;
        stopped_r <= stopped_r | res.stop;
      end
      if (ex_done && res.heap_re) begin
        ld_busy_r <= 1'b1;
      end else if (ld_done) begin
        ld_busy_r <= 1'b0;
      end
      if (rf_we && !clr_busy_r) begin
        fwd_v_r <= 1'b1;
      end
      if (ld_done || (ex_done && !res.heap_re)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_opcode_r  <= in_opcode;
      ex_field_a_r <= in_field_a;
      ex_field_b_r <= in_field_b;
      ex_field_c_r <= in_field_c;
      ex_ra_r      <= in_ra;
      ex_p0_r      <= in_p0;
      ex_p1_r      <= in_p1;
    end
    if (ex_done && res.heap_re) begin
      ld_dst_r <= ex_ra_r;
    end
    if (rf_we && !clr_busy_r) begin
      fwd_idx_r  <= rf_waddr;
      fwd_data_r <= rf_wdata;
    end
    if (ld_done) begin
      out_next_pc_r <= pc_r;
      out_status_r  <= vmx_pkg::ST_RUN;
      out_wval_r    <= {24'b0, heap_rdata};
      out_saddr_r   <= '0;
    end else if (ex_done && !res.heap_re) begin
      out_next_pc_r <= res.next_pc;
      out_status_r  <= res.status;
      out_wval_r    <= res.wval;
      out_saddr_r   <= res.saddr;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_next_pc         = out_next_pc_r;
  assign out_status          = out_status_r;
  assign out_written_value   = out_wval_r;
  assign out_service_address = out_saddr_r;

endmodule
